[rtl/mp2d_pkg.sv]
package mp2d_pkg;

	localparam int MAX_COLS_DEF   = 256;
	localparam int MAX_WINDOW_DEF = 8;
	localparam int MAX_ROWS       = 1024;

	localparam int PIX_W      = 8;
	localparam int ROW_W      = 10;
	localparam int OCOL_W     = 8;
	localparam int FROWS_W    = 11;
	localparam int FCOLS_W    = 9;
	localparam int WIN_W      = 4;
	localparam int STEP_W     = 4;
	localparam int CNT_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic signed [PIX_W-1:0] PIX_MIN = 8'sh80;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_LEN   = 3'd3;

	localparam logic [FROWS_W-1:0] FRAME_ROWS_RST = 11'd4;
	localparam logic [FCOLS_W-1:0] FRAME_COLS_RST = 9'd4;
	localparam logic [WIN_W-1:0]   WINDOW_LEN_RST = 4'd2;
	localparam logic [STEP_W-1:0]  STEP_LEN_RST   = 4'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_FLUSH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic init;
		logic en;
	} max_ctl_t;

endpackage

[rtl/mp2d_line_store.sv]
module mp2d_line_store #(
	parameter int DEPTH = 2048
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [$clog2(DEPTH)-1:0]             waddr,
	input  logic [mp2d_pkg::PIX_W-1:0]           wdata,
	input  logic                                 re,
	input  logic [$clog2(DEPTH)-1:0]             raddr,
	output logic [mp2d_pkg::PIX_W-1:0]           rdata
);
	import mp2d_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/mp2d_max_unit.sv]
module mp2d_max_unit (
	input  logic                              clk,
	input  mp2d_pkg::max_ctl_t                ctl,
	input  logic signed [mp2d_pkg::PIX_W-1:0] data,
	output logic signed [mp2d_pkg::PIX_W-1:0] best
);
	import mp2d_pkg::*;

	logic signed [PIX_W-1:0] best_q;

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			best_q <= PIX_MIN;
		end else if (ctl.en && (data > best_q)) begin
			best_q <= data;
		end
	end

	assign best = best_q;

endmodule

[rtl/max_pooling_2d.sv]
// A pixel that closes no window leaves the block idle, and the next beat can be taken at once.
// A pixel that closes a window stalls the input while the line store's
// single read port and the shared compare unit visit one window pixel per cycle.
// The result is then loaded into an output register, where it waits.
// Reset sets the registers to 4, 4, 2, 2 and the frame position to zero.
// The line store is not cleared; no clearing pass follows reset.
module max_pooling_2d #(
	parameter int MAX_COLS   = mp2d_pkg::MAX_COLS_DEF,
	parameter int MAX_WINDOW = mp2d_pkg::MAX_WINDOW_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [mp2d_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mp2d_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [mp2d_pkg::PIX_W-1:0]      pixel,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [mp2d_pkg::PIX_W-1:0]      pooled,
	output logic [mp2d_pkg::ROW_W-1:0]             out_row,
	output logic [mp2d_pkg::OCOL_W-1:0]            out_col,
	output logic                                   frame_last
);
	import mp2d_pkg::*;

	localparam int C_W   = $clog2(MAX_COLS);
	localparam int S_W   = $clog2(MAX_WINDOW);
	localparam int WV_W  = $clog2(MAX_WINDOW + 1);
	localparam int DEPTH = MAX_WINDOW * MAX_COLS;
	localparam int A_W   = $clog2(DEPTH);

	logic [FROWS_W-1:0] frame_rows_q;
	logic [FCOLS_W-1:0] frame_cols_q;
	logic [WIN_W-1:0]   window_len_q;
	logic [STEP_W-1:0]  step_len_q;
	logic               cfg_hit;

	logic [FROWS_W-1:0] rows_eff;
	logic [C_W:0]       cols_eff;
	logic [WV_W-1:0]    win_eff;
	logic [WV_W-1:0]    win_last;
	logic [STEP_W-1:0]  step_eff;
	logic [CNT_W-1:0]   win_m1;
	logic [CNT_W-1:0]   step_m1;

	logic [ROW_W-1:0] row_q;
	logic [C_W-1:0]   col_q;
	logic [S_W-1:0]   rslot_q;
	logic [CNT_W-1:0] rcnt_q;
	logic [CNT_W-1:0] ccnt_q;
	logic [ROW_W-1:0] orow_q;
	logic [C_W-1:0]   ocol_q;

	logic [S_W-1:0]   rslot_e;
	logic [CNT_W-1:0] rcnt_e;
	logic [CNT_W-1:0] ccnt_e;
	logic [ROW_W-1:0] orow_e;
	logic [C_W-1:0]   ocol_e;
	logic             row_hit;
	logic             col_hit;
	logic             hit;
	logic             row_end;
	logic             col_end;
	logic             accept;
	logic             last_r;
	logic             last_c;

	logic [S_W:0]     ts_sum;
	logic [S_W-1:0]   top_slot;
	logic [C_W-1:0]   left_col;

	state_t state_q;
	state_t state_d;
	logic   rd_en;
	logic   load_out;
	logic   last_issue;

	logic [S_W-1:0]   rd_slot_q;
	logic [C_W-1:0]   rd_col_q;
	logic [C_W-1:0]   left_q;
	logic [WV_W-1:0]  i_q;
	logic [WV_W-1:0]  j_q;
	logic             rd_vld_s1;
	logic [ROW_W-1:0] res_row_q;
	logic [C_W-1:0]   res_col_q;
	logic             res_last_q;

	logic [A_W-1:0]   waddr;
	logic [A_W-1:0]   raddr;
	logic [PIX_W-1:0] rdata;

	max_ctl_t                ctl;
	logic signed [PIX_W-1:0] best;

	logic                    out_valid_q;
	logic signed [PIX_W-1:0] pooled_q;
	logic [ROW_W-1:0]        out_row_q;
	logic [OCOL_W-1:0]       out_col_q;
	logic                    frame_last_q;

	// Configuration.
	assign cfg_hit = cfg_we && (cfg_index <= REG_STEP_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= FRAME_ROWS_RST;
			frame_cols_q <= FRAME_COLS_RST;
			window_len_q <= WINDOW_LEN_RST;
			step_len_q   <= STEP_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_ROWS: frame_rows_q <= cfg_data[FROWS_W-1:0];
				REG_FRAME_COLS: frame_cols_q <= cfg_data[FCOLS_W-1:0];
				REG_WINDOW_LEN: window_len_q <= cfg_data[WIN_W-1:0];
				REG_STEP_LEN:   step_len_q   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_rows_q == '0) begin
			rows_eff = FROWS_W'(1);
		end else if (frame_rows_q > FROWS_W'(MAX_ROWS)) begin
			rows_eff = FROWS_W'(MAX_ROWS);
		end else begin
			rows_eff = frame_rows_q;
		end
		if (frame_cols_q == '0) begin
			cols_eff = (C_W+1)'(1);
		end else if (32'(frame_cols_q) > 32'(MAX_COLS)) begin
			cols_eff = (C_W+1)'(MAX_COLS);
		end else begin
			cols_eff = (C_W+1)'(frame_cols_q);
		end
		if (window_len_q == '0) begin
			win_eff = WV_W'(1);
		end else if (32'(window_len_q) > 32'(MAX_WINDOW)) begin
			win_eff = WV_W'(MAX_WINDOW);
		end else begin
			win_eff = WV_W'(window_len_q);
		end
		step_eff = (step_len_q == '0) ? STEP_W'(1) : step_len_q;
	end

	assign win_last = win_eff - WV_W'(1);
	assign win_m1   = CNT_W'(win_last);
	assign step_m1  = CNT_W'(step_eff - STEP_W'(1));

	// Frame position and window phase; a zero row or column reloads its phase.
	assign ccnt_e  = (col_q == '0) ? win_m1 : ccnt_q;
	assign ocol_e  = (col_q == '0) ? '0 : ocol_q;
	assign rcnt_e  = (row_q == '0) ? win_m1 : rcnt_q;
	assign orow_e  = (row_q == '0) ? '0 : orow_q;
	assign rslot_e = (row_q == '0) ? '0 : rslot_q;
	assign col_hit = (ccnt_e == '0);
	assign row_hit = (rcnt_e == '0);
	assign hit     = col_hit && row_hit;
	assign col_end = (((C_W+1)'(col_q) + (C_W+1)'(1)) == cols_eff);
	assign row_end = ((FROWS_W'(row_q) + FROWS_W'(1)) == rows_eff);
	assign accept  = in_valid && !in_stall;

	assign last_r = ((12'(row_q) + 12'(step_eff)) >= 12'(rows_eff));
	assign last_c = (((C_W+2)'(col_q) + (C_W+2)'(step_eff)) >= (C_W+2)'(cols_eff));

	assign ts_sum   = (S_W+1)'(rslot_e) + (S_W+1)'(MAX_WINDOW) - (S_W+1)'(win_last);
	assign top_slot = (32'(ts_sum) >= 32'(MAX_WINDOW)) ?
		S_W'(ts_sum - (S_W+1)'(MAX_WINDOW)) : S_W'(ts_sum);
	assign left_col = col_q - C_W'(win_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			rslot_q <= '0;
			rcnt_q  <= '0;
			ccnt_q  <= '0;
			orow_q  <= '0;
			ocol_q  <= '0;
		end else if (cfg_hit) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q   <= '0;
				row_q   <= row_end ? '0 : row_q + ROW_W'(1);
				rcnt_q  <= row_hit ? step_m1 : rcnt_e - CNT_W'(1);
				orow_q  <= orow_e + ROW_W'(row_hit);
				rslot_q <= (32'(rslot_e) == MAX_WINDOW - 1) ? '0 : rslot_e + S_W'(1);
			end else begin
				col_q  <= col_q + C_W'(1);
				ccnt_q <= col_hit ? step_m1 : ccnt_e - CNT_W'(1);
				ocol_q <= ocol_e + C_W'(col_hit);
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign last_issue = (i_q == win_last) && (j_q == win_last);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept && hit) state_d = ST_READ;
			ST_READ:  if (last_issue) state_d = ST_FLUSH;
			ST_FLUSH: state_d = ST_DONE;
			ST_DONE:  if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_stall = 1'b0;
			ST_READ:  rd_en = 1'b1;
			ST_FLUSH: ;
			ST_DONE:  load_out = !out_valid_q || !out_stall;
			default:  ;
		endcase
	end

	// Window walk over the line store.
	always_ff @(posedge clk) begin
		if (accept && hit) begin
			rd_slot_q  <= top_slot;
			rd_col_q   <= left_col;
			left_q     <= left_col;
			i_q        <= '0;
			j_q        <= '0;
			res_row_q  <= orow_e;
			res_col_q  <= ocol_e;
			res_last_q <= last_r && last_c;
		end else if (rd_en) begin
			if (j_q == win_last) begin
				j_q       <= '0;
				i_q       <= i_q + WV_W'(1);
				rd_col_q  <= left_q;
				rd_slot_q <= (32'(rd_slot_q) == MAX_WINDOW - 1) ? '0 : rd_slot_q + S_W'(1);
			end else begin
				j_q      <= j_q + WV_W'(1);
				rd_col_q <= rd_col_q + C_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	assign waddr = A_W'(rslot_e) * A_W'(MAX_COLS) + A_W'(col_q);
	assign raddr = A_W'(rd_slot_q) * A_W'(MAX_COLS) + A_W'(rd_col_q);

	mp2d_line_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept),
		.waddr (waddr),
		.wdata (pixel),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign ctl.init = accept && hit;
	assign ctl.en   = rd_vld_s1;

	mp2d_max_unit u_max (
		.clk  (clk),
		.ctl  (ctl),
		.data ($signed(rdata)),
		.best (best)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pooled_q     <= best;
			out_row_q    <= res_row_q;
			out_col_q    <= OCOL_W'(res_col_q);
			frame_last_q <= res_last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign pooled     = pooled_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign frame_last = frame_last_q;

	a_flush_data: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> rd_vld_s1)
		else $error("last window pixel not read back in flush");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result beat raised outside the done state");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> (32'(rd_slot_q) < MAX_WINDOW))
		else $error("line store row slot out of range");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> (32'(rd_col_q) < 32'(cols_eff)))
		else $error("window column beyond the frame");

endmodule

[test/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mp2d_pkg::*;

	typedef struct packed {
		logic signed [PIX_W-1:0] pooled;
		logic [ROW_W-1:0]        row;
		logic [OCOL_W-1:0]       col;
		logic                    last;
	} pool_res_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_PIX,
		ROW_PIX_EXP
	} row_kind_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [CFG_IDX_W-1:0]    idx;
		logic [CFG_DATA_W-1:0]   data;
		logic signed [PIX_W-1:0] px;
		pool_res_t               res;
	} dir_row_t;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int DIR_ROWS      = 37;
	localparam int SETTLE_CYCLES = 100;
	localparam int RANDOM_ITEMS  = 1200;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int STORE_DEPTH   = MAX_WINDOW_DEF * MAX_COLS_DEF;
	localparam pool_res_t NO_RES = '0;

	// Reset geometry first: a 4x4 frame pooled 2x2 with stride 2, then registers
	// out of range, an ignored write, the largest geometry and a window wider than
	// the frame.
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{ROW_PIX,     '0, '0, 8'sh80, NO_RES},
		'{ROW_PIX,     '0, '0, 8'sh80, NO_RES},
		'{ROW_PIX,     '0, '0, 8'sh7f, NO_RES},
		'{ROW_PIX,     '0, '0, 8'sh05, NO_RES},
		'{ROW_PIX,     '0, '0, 8'sh80, NO_RES},
		'{ROW_PIX_EXP, '0, '0, 8'sh80, '{8'sh80, 10'd0, 8'd0, 1'b0}},
		'{ROW_PIX,     '0, '0, 8'sh00, NO_RES},
		'{ROW_PIX_EXP, '0, '0, 8'shff, '{8'sh7f, 10'd0, 8'd1, 1'b0}},
		'{ROW_PIX,     '0, '0, 8'sh03, NO_RES},
		'{ROW_PIX,     '0, '0, 8'shf9, NO_RES},
		'{ROW_PIX,     '0, '0, 8'sh80, NO_RES},
		'{ROW_PIX,     '0, '0, 8'sh80, NO_RES},
		'{ROW_PIX,     '0, '0, 8'sh64, NO_RES},
		'{ROW_PIX_EXP, '0, '0, 8'sh9c, '{8'sh64, 10'd1, 8'd0, 1'b0}},
		'{ROW_PIX,     '0, '0, 8'sh80, NO_RES},
		'{ROW_PIX_EXP, '0, '0, 8'sh80, '{8'sh80, 10'd1, 8'd1, 1'b1}},
		'{ROW_CFG, REG_FRAME_ROWS, 11'd0, 8'sh00, NO_RES},
		'{ROW_CFG, REG_FRAME_COLS, 11'd0, 8'sh00, NO_RES},
		'{ROW_CFG, REG_WINDOW_LEN, 11'd0, 8'sh00, NO_RES},
		'{ROW_CFG, REG_STEP_LEN,   11'd0, 8'sh00, NO_RES},
		'{ROW_PIX_EXP, '0, '0, 8'sh80, '{8'sh80, 10'd0, 8'd0, 1'b1}},
		'{ROW_PIX_EXP, '0, '0, 8'sh7f, '{8'sh7f, 10'd0, 8'd0, 1'b1}},
		'{ROW_CFG, REG_UNUSED, 11'h7ff, 8'sh00, NO_RES},
		'{ROW_PIX_EXP, '0, '0, 8'sh55, '{8'sh55, 10'd0, 8'd0, 1'b1}},
		'{ROW_CFG, REG_FRAME_ROWS, 11'h7ff, 8'sh00, NO_RES},
		'{ROW_CFG, REG_FRAME_COLS, 11'h1ff, 8'sh00, NO_RES},
		'{ROW_CFG, REG_WINDOW_LEN, 11'h00f, 8'sh00, NO_RES},
		'{ROW_CFG, REG_STEP_LEN,   11'h00f, 8'sh00, NO_RES},
		'{ROW_PIX,     '0, '0, 8'shff, NO_RES},
		'{ROW_PIX,     '0, '0, 8'sh00, NO_RES},
		'{ROW_CFG, REG_FRAME_ROWS, 11'd3, 8'sh00, NO_RES},
		'{ROW_CFG, REG_FRAME_COLS, 11'd3, 8'sh00, NO_RES},
		'{ROW_CFG, REG_WINDOW_LEN, 11'd4, 8'sh00, NO_RES},
		'{ROW_CFG, REG_STEP_LEN,   11'd1, 8'sh00, NO_RES},
		'{ROW_PIX,     '0, '0, 8'sh01, NO_RES},
		'{ROW_PIX,     '0, '0, 8'shfe, NO_RES},
		'{ROW_PIX,     '0, '0, 8'sh40, NO_RES}
	};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [PIX_W-1:0]  pixel = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [PIX_W-1:0]  pooled;
	logic [ROW_W-1:0]         out_row;
	logic [OCOL_W-1:0]        out_col;
	logic                     frame_last;

	logic [FROWS_W-1:0]       rows_reg = FRAME_ROWS_RST;
	logic [FCOLS_W-1:0]       cols_reg = FRAME_COLS_RST;
	logic [WIN_W-1:0]         win_reg = WINDOW_LEN_RST;
	logic [STEP_W-1:0]        step_reg = STEP_LEN_RST;
	logic signed [PIX_W-1:0]  pixel_lines [STORE_DEPTH];
	int                       row_pos = 0;
	int                       col_pos = 0;

	pool_res_t                pending_pools [$];
	pool_res_t                want_pool;
	int                       send_gap_pct = 0;
	int                       stall_pct = 0;
	bit                       quiet = 1'b1;
	int                       mismatches = 0;
	int                       cycle_count = 0;
	int                       pixels_sent = 0;

	max_pooling_2d u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel      (pixel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pooled     (pooled),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_last (frame_last)
	);

	always #10 clk = ~clk;

	function automatic int eff_rows();
		if (rows_reg == 0) return 1;
		return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
	endfunction

	function automatic int eff_cols();
		if (cols_reg == 0) return 1;
		return (cols_reg > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_reg);
	endfunction

	function automatic int eff_win();
		if (win_reg == 0) return 1;
		return (win_reg > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(win_reg);
	endfunction

	function automatic int eff_step();
		return (step_reg == 0) ? 1 : int'(step_reg);
	endfunction

	// Stores the pixel at the current frame position and, when it closes a
	// window on the stride grid, returns that window's maximum and position.
	function automatic bit pool_window(input logic signed [PIX_W-1:0] px,
			output pool_res_t res);
		int rows, cols, win, step, r, c, top, left, best, orow, ocol, v;
		bit hit;
		rows = eff_rows();
		cols = eff_cols();
		win = eff_win();
		step = eff_step();
		r = row_pos;
		c = col_pos;
		if (r >= rows) r = 0;
		if (c >= cols) c = 0;
		pixel_lines[(r % MAX_WINDOW_DEF) * MAX_COLS_DEF + c] = px;
		hit = (r + 1 >= win) && (c + 1 >= win) &&
			((r + 1 - win) % step == 0) && ((c + 1 - win) % step == 0);
		res = NO_RES;
		if (hit) begin
			top = r + 1 - win;
			left = c + 1 - win;
			orow = top / step;
			ocol = left / step;
			best = PIX_MIN;
			for (int i = 0; i < win; i++) begin
				for (int j = 0; j < win; j++) begin
					v = pixel_lines[(((top + i) % MAX_WINDOW_DEF) * MAX_COLS_DEF + left + j)
						% STORE_DEPTH];
					if (v > best) best = v;
				end
			end
			res.pooled = best[PIX_W-1:0];
			res.row = orow[ROW_W-1:0];
			res.col = ocol[OCOL_W-1:0];
			res.last = (orow == (rows - win) / step) && (ocol == (cols - win) / step);
		end
		c++;
		if (c >= cols) begin
			c = 0;
			r++;
			if (r >= rows) r = 0;
		end
		row_pos = r;
		col_pos = c;
		return hit;
	endfunction

	// Registers change only with the pipeline drained and settled.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		if (!quiet) begin
			in_valid = 1'b0;
			while (pending_pools.size() != 0) @(negedge clk);
			repeat (SETTLE_CYCLES) @(negedge clk);
			quiet = 1'b1;
		end
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_FRAME_ROWS: rows_reg = data[FROWS_W-1:0];
			REG_FRAME_COLS: cols_reg = data[FCOLS_W-1:0];
			REG_WINDOW_LEN: win_reg = data[WIN_W-1:0];
			REG_STEP_LEN:   step_reg = data[STEP_W-1:0];
			default: ;
		endcase
		if (idx <= REG_STEP_LEN) begin
			row_pos = 0;
			col_pos = 0;
		end
	endtask

	task automatic program_setup(input int rows, input int cols, input int win,
			input int step);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom_range(0, 2047));
		if ($urandom_range(0, 1)) junk = '0;
		if ($urandom_range(0, 3) == 0)
			cfg_write(CFG_IDX_W'($urandom_range(REG_STEP_LEN + 1, REG_UNUSED)), junk);
		cfg_write(REG_FRAME_ROWS, rows[CFG_DATA_W-1:0]);
		cfg_write(REG_FRAME_COLS, {junk[CFG_DATA_W-1:FCOLS_W], cols[FCOLS_W-1:0]});
		cfg_write(REG_WINDOW_LEN, {junk[CFG_DATA_W-1:WIN_W], win[WIN_W-1:0]});
		cfg_write(REG_STEP_LEN, {junk[CFG_DATA_W-1:STEP_W], step[STEP_W-1:0]});
	endtask

	task automatic send_pixel(input logic signed [PIX_W-1:0] px, input bit typed,
			input pool_res_t typed_res);
		pool_res_t res;
		bit hit;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		pixel = px;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		hit = pool_window(px, res);
		if (typed) pending_pools.push_back(typed_res);
		else if (hit) pending_pools.push_back(res);
		quiet = 1'b0;
		pixels_sent++;
		@(negedge clk);
	endtask

	always @(negedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pools.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: pooled %0d row %0d col %0d last %0b",
						pooled, out_row, out_col, frame_last);
			end else begin
				want_pool = pending_pools.pop_front();
				if (want_pool.pooled !== pooled || want_pool.row !== out_row ||
						want_pool.col !== out_col || want_pool.last !== frame_last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
							want_pool.pooled, want_pool.row, want_pool.col, want_pool.last,
							pooled, out_row, out_col, frame_last);
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		int setup_kind, n, cap, phase, w;
		logic signed [PIX_W-1:0] px;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_CFG)
				cfg_write(DIRECTED[i].idx, DIRECTED[i].data);
			else
				send_pixel(DIRECTED[i].px, DIRECTED[i].kind == ROW_PIX_EXP, DIRECTED[i].res);
		end

		pixels_sent = 0;
		phase = 0;
		while (pixels_sent < RANDOM_ITEMS) begin
			case (phase % 4)
				0: begin send_gap_pct = 0; stall_pct = 0; end
				1: begin send_gap_pct = 78; stall_pct = 0; end
				2: begin send_gap_pct = 0; stall_pct = 78; end
				default: begin send_gap_pct = 23; stall_pct = 23; end
			endcase
			phase++;
			cap = 150;
			setup_kind = $urandom_range(0, 9);
			case (setup_kind)
				0: cfg_write(CFG_IDX_W'($urandom_range(REG_STEP_LEN + 1, REG_UNUSED)),
					CFG_DATA_W'($urandom_range(0, 2047)));
				1: begin
					cap = 520;
					program_setup($urandom_range(1, 3),
						$urandom_range(0, 1) ? MAX_COLS_DEF : $urandom_range(257, 511),
						$urandom_range(1, 2), $urandom_range(1, 2));
				end
				2: program_setup($urandom_range(0, 1) ? 0 : $urandom_range(1025, 2047),
					$urandom_range(0, 1) ? 0 : $urandom_range(8, 12),
					$urandom_range(0, 1) ? 0 : $urandom_range(9, 15),
					$urandom_range(0, 1) ? 0 : $urandom_range(9, 15));
				3: begin
					w = $urandom_range(5, MAX_WINDOW_DEF);
					program_setup($urandom_range(w - 1, w + 3), $urandom_range(w - 1, w + 3), w,
						$urandom_range(1, 3));
				end
				4: program_setup($urandom_range(8, 9), $urandom_range(8, 17), MAX_WINDOW_DEF,
					MAX_WINDOW_DEF);
				5: program_setup(1, $urandom_range(1, 20), 1, 1);
				default: program_setup($urandom_range(1, 10), $urandom_range(1, 10),
					$urandom_range(1, 4), $urandom_range(1, 4));
			endcase
			n = eff_rows() * eff_cols() * $urandom_range(1, 2) + $urandom_range(0, 3);
			if (n > cap) n = cap;
			if (n > RANDOM_ITEMS - pixels_sent) n = RANDOM_ITEMS - pixels_sent;
			repeat (n) begin
				if ($urandom_range(0, 63) == 0) begin
					in_valid = 1'b0;
					while (pending_pools.size() != 0) @(negedge clk);
				end
				px = PIX_W'($urandom_range(0, 255));
				if ($urandom_range(0, 7) == 0) px = $urandom_range(0, 1) ? 8'sh7f : 8'sh80;
				send_pixel(px, 1'b0, NO_RES);
			end
		end

		in_valid = 1'b0;
		while (pending_pools.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_pools.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
